// File: hdl/tgam_pkg.sv
package tgam_pkg;

    // Default sizes
    localparam int MAX_RANK_DEF  = 8;
    localparam int LOC_DEPTH_DEF = 256;
    localparam int ADDR_W_DEF    = 32;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int DIV_STEPS = DATA_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOC_EN = 2'd1;

    typedef enum logic [1:0] {
        OP_SRC_STRIDE = 2'd0,
        OP_OUT_STRIDE = 2'd1,
        OP_LOC_ENTRY  = 2'd2,
        OP_MAP        = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_ZERO_OS  = 2'd1,
        ERR_LOC_OOR  = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    // One item as it moves down the chain
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [2:0]        dim;
        logic [7:0]        entry;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] pos;   // remaining position
        logic              last;
        t_err              err;
        logic [ACC_W-1:0]  acc;
    } t_item;

    // Divider working state, one quotient bit per step
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] nq;    // dividend bits shift out, quotient bits shift in
        logic [DATA_W-1:0] os;
        logic [DATA_W-1:0] ss;
    } t_div;

endpackage

// File: hdl/tensor_gather_address_map_unit.sv
// Strided tensor gather address generator. One item is accepted per clock
// while the result side keeps up; loads and maps may be freely interleaved.
// The block is a chain of MAX_RANK cells, one per dimension, each holding
// that dimension's strides and locator table. Each cell divides the
// remaining position by its output stride one quotient bit per stage
// (32 stages), then reads the locator table, multiplies by the source
// stride and accumulates, for 35 stages per cell. Every item passes through
// all cells and the output register whatever the rank. Load items travel the
// same chain and update a cell as they pass it, so every map sees exactly the
// loads that came before it. The first error in dimension order is reported,
// with a zero address. Configuration writes are always ready.
module tensor_gather_address_map_unit #(
    parameter int MAX_RANK  = tgam_pkg::MAX_RANK_DEF,
    parameter int LOC_DEPTH = tgam_pkg::LOC_DEPTH_DEF,
    parameter int ADDR_W    = tgam_pkg::ADDR_W_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,   // dim[2:0], entry[10:3], value[42:11],
                                          // position[74:43], zero fill
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    input  logic        i_s_axis_tlast,   // last
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // src_addr[31:0]
    output logic [1:0]  o_m_axis_tuser,   // error[1:0]
    output logic        o_m_axis_tlast,   // last_out
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tgam_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tgam_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int RW = $clog2(MAX_RANK + 1);

    logic            w_en;
    logic [3:0]      r_rank;
    logic [7:0]      r_loc_en;
    logic [RW-1:0]   w_rank;
    tgam_pkg::t_item w_in;
    tgam_pkg::t_item w_chain [MAX_RANK+1];
    logic            r_out_valid;
    logic [31:0]     r_out_addr;
    tgam_pkg::t_err  r_out_err;
    logic            r_out_last;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank   <= 4'd1;
            r_loc_en <= 8'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tgam_pkg::CFG_RANK) begin
                r_rank <= i_cfg_data[3:0];
            end else if (i_cfg_index == tgam_pkg::CFG_LOC_EN) begin
                r_loc_en <= i_cfg_data;
            end
        end
    end

    // Rank clamped to 1..MAX_RANK
    always_comb begin
        if (r_rank == 4'd0) begin
            w_rank = RW'(1);
        end else if (32'(r_rank) > 32'(MAX_RANK)) begin
            w_rank = RW'(MAX_RANK);
        end else begin
            w_rank = RW'(r_rank);
        end
    end

    // Chain advances whenever the output register can take a result
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_comb begin
        w_in.valid = i_s_axis_tvalid;
        w_in.op    = tgam_pkg::t_op'(i_s_axis_tuser);
        w_in.dim   = i_s_axis_tdata[2:0];
        w_in.entry = i_s_axis_tdata[10:3];
        w_in.value = i_s_axis_tdata[42:11];
        w_in.pos   = i_s_axis_tdata[74:43];
        w_in.last  = i_s_axis_tlast;
        w_in.err   = tgam_pkg::ERR_OK;
        w_in.acc   = '0;
    end

    assign w_chain[0] = w_in;

    for (genvar c = 0; c < MAX_RANK; c++) begin : g_cell
        tgam_cell #(
            .CELL     (c),
            .MAX_RANK (MAX_RANK),
            .LOC_DEPTH(LOC_DEPTH),
            .ADDR_W   (ADDR_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_rank  (w_rank),
            .i_loc_en((c < 8) ? r_loc_en[c % 8] : 1'b0),
            .i_item  (w_chain[c]),
            .o_item  (w_chain[c+1])
        );
    end

    // Output register: map items only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_chain[MAX_RANK].valid
                           && (w_chain[MAX_RANK].op == tgam_pkg::OP_MAP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_err  <= w_chain[MAX_RANK].err;
            r_out_last <= w_chain[MAX_RANK].last;
            r_out_addr <= (w_chain[MAX_RANK].err == tgam_pkg::ERR_OK)
                          ? w_chain[MAX_RANK].acc[31:0] : 32'd0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_addr;
    assign o_m_axis_tuser  = r_out_err;
    assign o_m_axis_tlast  = r_out_last;

    // Checks
    a_err_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != tgam_pkg::ERR_OK)) |-> (o_m_axis_tdata == 32'd0))
        else $error("error result with nonzero address");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rank != '0) && (32'(w_rank) <= 32'(MAX_RANK)))
        else $error("effective rank out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && !$past(o_s_axis_tready)))
        else $error("stalled result lost or chain advanced");

endmodule

// File: hdl/tgam_div_stage.sv
module tgam_div_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  tgam_pkg::t_item i_item,
    input  tgam_pkg::t_div  i_div,
    output tgam_pkg::t_item o_item,
    output tgam_pkg::t_div  o_div
);

    logic [tgam_pkg::DATA_W:0] w_trial;
    logic                      w_ge;
    tgam_pkg::t_item           r_item;
    tgam_pkg::t_div            r_div;
    tgam_pkg::t_div            n_div;

    // One restoring division step
    always_comb begin
        w_trial = {i_div.rem, i_div.nq[tgam_pkg::DATA_W-1]};
        w_ge    = (w_trial >= {1'b0, i_div.os});
        n_div   = i_div;
        n_div.rem = w_ge ? tgam_pkg::DATA_W'(w_trial - {1'b0, i_div.os})
                         : w_trial[tgam_pkg::DATA_W-1:0];
        n_div.nq  = {i_div.nq[tgam_pkg::DATA_W-2:0], w_ge};
    end

    // Stage register; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= i_item;
            r_div  <= n_div;
        end
    end

    assign o_item = r_item;
    assign o_div  = r_div;

endmodule

// File: hdl/tgam_cell.sv
module tgam_cell #(
    parameter int CELL      = 0,
    parameter int MAX_RANK  = tgam_pkg::MAX_RANK_DEF,
    parameter int LOC_DEPTH = tgam_pkg::LOC_DEPTH_DEF,
    parameter int ADDR_W    = tgam_pkg::ADDR_W_DEF,
    localparam int RW       = $clog2(MAX_RANK + 1),
    localparam int LIW      = $clog2(LOC_DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [RW-1:0]   i_rank,
    input  logic            i_loc_en,
    input  tgam_pkg::t_item i_item,
    output tgam_pkg::t_item o_item
);

    localparam int N = tgam_pkg::DIV_STEPS;

    logic                         w_active;
    logic                         w_is_load;
    logic [tgam_pkg::DATA_W-1:0]  r_os;
    logic [tgam_pkg::DATA_W-1:0]  r_ss;
    tgam_pkg::t_div               w_div0;
    tgam_pkg::t_item              w_item [N+1];
    tgam_pkg::t_div               w_div  [N+1];

    assign w_active  = (32'(CELL) < 32'(i_rank));
    assign w_is_load = i_item.valid && (32'(i_item.dim) == 32'(CELL));

    // Stride registers, written as load items enter the cell
    always_ff @(posedge i_clk) begin
        if (i_en && w_is_load) begin
            if (i_item.op == tgam_pkg::OP_SRC_STRIDE) begin
                r_ss <= i_item.value;
            end
            if (i_item.op == tgam_pkg::OP_OUT_STRIDE) begin
                r_os <= i_item.value;
            end
        end
    end

    // Divider pipeline
    always_comb begin
        w_div0.rem = '0;
        w_div0.nq  = i_item.pos;
        w_div0.os  = r_os;
        w_div0.ss  = r_ss;
    end

    assign w_item[0] = i_item;
    assign w_div[0]  = w_div0;

    for (genvar k = 0; k < N; k++) begin : g_div
        tgam_div_stage u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_item (w_item[k]),
            .i_div  (w_div[k]),
            .o_item (w_item[k+1]),
            .o_div  (w_div[k+1])
        );
    end

    // Locator stage: table read, zero stride and range checks
    tgam_pkg::t_item             n_l_item, r_l_item;
    logic [tgam_pkg::DATA_W-1:0] r_l_q, r_l_ss;
    logic                        r_l_use;
    logic                        w_map_l, w_loc_wr;
    logic [tgam_pkg::DATA_W-1:0] r_loc_mem [LOC_DEPTH];
    logic [tgam_pkg::DATA_W-1:0] r_loc_rd;

    assign w_map_l  = w_item[N].valid && (w_item[N].op == tgam_pkg::OP_MAP) && w_active;
    assign w_loc_wr = w_item[N].valid && (w_item[N].op == tgam_pkg::OP_LOC_ENTRY)
                      && (32'(w_item[N].dim) == 32'(CELL))
                      && (32'(w_item[N].entry) < 32'(LOC_DEPTH));

    always_comb begin
        n_l_item = w_item[N];
        if (w_map_l) begin
            n_l_item.pos = w_div[N].rem;
            if (w_item[N].err == tgam_pkg::ERR_OK) begin
                if (w_div[N].os == '0) begin
                    n_l_item.err = tgam_pkg::ERR_ZERO_OS;
                end else if (i_loc_en && (w_div[N].nq >= 32'(LOC_DEPTH))) begin
                    n_l_item.err = tgam_pkg::ERR_LOC_OOR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_loc_wr) begin
                r_loc_mem[LIW'(w_item[N].entry)] <= w_item[N].value;
            end
            r_loc_rd <= r_loc_mem[w_div[N].nq[LIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_item.valid <= 1'b0;
        end else if (i_en) begin
            r_l_item <= n_l_item;
            r_l_q    <= w_div[N].nq;
            r_l_ss   <= w_div[N].ss;
            r_l_use  <= i_loc_en;
        end
    end

    // Multiply stage
    tgam_pkg::t_item            r_m_item;
    logic [tgam_pkg::ACC_W-1:0] r_prod;
    logic [tgam_pkg::DATA_W-1:0] w_idx;

    assign w_idx = r_l_use ? r_loc_rd : r_l_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_item.valid <= 1'b0;
        end else if (i_en) begin
            r_m_item <= r_l_item;
            r_prod   <= {32'd0, w_idx} * {32'd0, r_l_ss};
        end
    end

    // Accumulate stage with address range check
    tgam_pkg::t_item          n_a_item, r_a_item;
    logic [tgam_pkg::ACC_W:0] w_sum;

    always_comb begin
        w_sum    = {1'b0, r_m_item.acc} + {1'b0, r_prod};
        n_a_item = r_m_item;
        if (r_m_item.valid && (r_m_item.op == tgam_pkg::OP_MAP) && w_active
            && (r_m_item.err == tgam_pkg::ERR_OK)) begin
            if ((w_sum >> ADDR_W) != '0) begin
                n_a_item.err = tgam_pkg::ERR_OVERFLOW;
            end else begin
                n_a_item.acc = w_sum[tgam_pkg::ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_item.valid <= 1'b0;
        end else if (i_en) begin
            r_a_item <= n_a_item;
        end
    end

    assign o_item = r_a_item;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY_WAIT = 300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int N_PHASES     = 8;
    localparam int MAPS_PER_PH  = 55;

    // spare register indexes, writes to these are dropped
    localparam logic [tgam_pkg::CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [tgam_pkg::CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    typedef struct {
        tgam_pkg::t_op op;
        logic [2:0]    dim;
        logic [7:0]    entry;
        logic [31:0]   value;
        logic [31:0]   pos;
        logic          last;
    } t_gather_item;

    typedef struct {
        logic [31:0]    addr;
        tgam_pkg::t_err err;
        logic           last;
    } t_addr_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [tgam_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tgam_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    tensor_gather_address_map_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block state, with written flags per entry
    logic [31:0] src_stride [8];
    logic [31:0] out_stride [8];
    logic [31:0] loc_tab [8][256];
    bit          src_wr [8];
    bit          out_wr [8];
    bit          loc_wr [8][256];
    logic [3:0]  rank_reg = 4'd1;
    logic [7:0]  loc_en_reg = 8'd0;

    t_gather_item pending_items[$];
    t_addr_result expected_addrs[$];
    int n_accepted = 0;
    int n_fails = 0;
    int rx_hold = 0;
    bit rx_hold_done = 1'b0;
    int cycles = 0;

    // shape of the current phase
    logic [63:0] dim_size [8];
    logic [63:0] tensor_total;

    function automatic int tx_idle_pct();
        if (n_accepted < 280) return 28;
        if (n_accepted < 560) return 59;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (n_accepted < 280) return 59;
        if (n_accepted < 560) return 28;
        return 0;
    endfunction

    // mixed-radix walk; returns 0 when the walk would touch an unwritten entry
    function automatic bit gather_addr(input logic [31:0] pos, output logic [31:0] addr,
                                       output tgam_pkg::t_err err);
        logic [63:0] t, acc, q, idx, prod;
        int r;
        t = 64'(pos);
        acc = '0;
        addr = '0;
        err = tgam_pkg::ERR_OK;
        r = (rank_reg == 0) ? 1 : ((rank_reg > 8) ? 8 : int'(rank_reg));
        for (int d = 0; d < r; d++) begin
            if (!out_wr[d]) return 1'b0;
            if (out_stride[d] == 0) begin
                err = tgam_pkg::ERR_ZERO_OS;
                return 1'b1;
            end
            q = t / out_stride[d];
            t = t % out_stride[d];
            if (loc_en_reg[d]) begin
                if (q >= 256) begin
                    err = tgam_pkg::ERR_LOC_OOR;
                    return 1'b1;
                end
                if (!loc_wr[d][q]) return 1'b0;
                idx = 64'(loc_tab[d][q]);
            end else begin
                idx = q;
            end
            if (!src_wr[d]) return 1'b0;
            prod = idx * 64'(src_stride[d]);
            if (prod > 64'hFFFF_FFFF - acc) begin
                err = tgam_pkg::ERR_OVERFLOW;
                return 1'b1;
            end
            acc = acc + prod;
        end
        addr = acc[31:0];
        return 1'b1;
    endfunction

    task automatic send_load(input tgam_pkg::t_op op, input logic [2:0] dim,
                             input logic [7:0] entry, input logic [31:0] value);
        t_gather_item it;
        it.op = op;
        it.dim = dim;
        it.entry = entry;
        it.value = value;
        it.pos = $urandom;
        it.last = 1'($urandom_range(0, 1));
        case (op)
            tgam_pkg::OP_SRC_STRIDE: begin
                src_stride[dim] = value;
                src_wr[dim] = 1'b1;
            end
            tgam_pkg::OP_OUT_STRIDE: begin
                out_stride[dim] = value;
                out_wr[dim] = 1'b1;
            end
            default: begin
                loc_tab[dim][entry] = value;
                loc_wr[dim][entry] = 1'b1;
            end
        endcase
        pending_items.push_back(it);
    endtask

    task automatic send_map(input logic [31:0] pos, input logic last);
        t_gather_item it;
        t_addr_result r;
        tgam_pkg::t_err e;
        logic [31:0] a;
        if (gather_addr(pos, a, e)) begin
            it.op = tgam_pkg::OP_MAP;
            it.dim = 3'($urandom);
            it.entry = 8'($urandom);
            it.value = $urandom;
            it.pos = pos;
            it.last = last;
            r.addr = a;
            r.err = e;
            r.last = last;
            pending_items.push_back(it);
            expected_addrs.push_back(r);
        end
    endtask

    task automatic cfg_write(input logic [tgam_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == tgam_pkg::CFG_RANK) rank_reg = data[3:0];
        else if (idx == tgam_pkg::CFG_LOC_EN) loc_en_reg = data;
    endtask

    // wait until the block has drained, then let the pipeline empty
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_addrs.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_src_stride();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd0;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    function automatic logic [31:0] rand_loc_value(input int d);
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $urandom_range(0, int'(dim_size[d]) * 2);
    endfunction

    // pick a shape and load strides for all dims, plus the enabled locator tables
    task automatic setup_shape(input bit big_first);
        logic [63:0] os;
        int r;
        r = (rank_reg == 0) ? 1 : ((rank_reg > 8) ? 8 : int'(rank_reg));
        for (int d = 0; d < 8; d++) dim_size[d] = 64'($urandom_range(1, 6));
        if (big_first) dim_size[0] = 64'd4;
        os = 64'd1;
        for (int d = 7; d >= 0; d--) begin
            if (d < r) begin
                send_load(tgam_pkg::OP_OUT_STRIDE, 3'(d), 8'($urandom), os[31:0]);
                os = os * dim_size[d];
            end else begin
                send_load(tgam_pkg::OP_OUT_STRIDE, 3'(d), 8'($urandom),
                          $urandom_range(1, 64));
            end
            send_load(tgam_pkg::OP_SRC_STRIDE, 3'(d), 8'($urandom), rand_src_stride());
        end
        tensor_total = os;
        for (int d = 0; d < 8; d++)
            if (loc_en_reg[d])
                for (int e = 0; e < dim_size[d]; e++)
                    send_load(tgam_pkg::OP_LOC_ENTRY, 3'(d), 8'(e), rand_loc_value(d));
    endtask

    function automatic logic [31:0] rand_position();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) return $urandom_range(0, int'(tensor_total - 1));
        if (k < 9) return $urandom;
        return tensor_total[31:0] + $urandom_range(0, 3);
    endfunction

    // stimulus
    initial begin
        logic [3:0] ranks [N_PHASES];
        logic [7:0] loc_ens [N_PHASES];
        logic [2:0] d;
        ranks = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd0};
        loc_ens = '{8'h55, 8'h00, 8'hFF, 8'hFF, 8'hAA, 8'h00, 8'hFF, 8'h00};
        ranks[7] = 4'($urandom_range(1, 8));
        loc_ens[5] = 8'($urandom);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            cfg_write(tgam_pkg::CFG_RANK, {4'($urandom_range(0, 15)), ranks[ph]});
            cfg_write(tgam_pkg::CFG_LOC_EN, loc_ens[ph]);
            if (ph == 1) begin
                cfg_write(CFG_SPARE2, 8'($urandom));
                cfg_write(CFG_SPARE3, 8'($urandom));
            end
            setup_shape(ph == 0);
            if (ph == 0) begin
                // corners: zero and full position, table end entry
                send_map(32'd0, 1'b1);
                send_map(32'hFFFF_FFFF, 1'b0);
                send_load(tgam_pkg::OP_LOC_ENTRY, 3'd7, 8'd255, 32'hFFFF_FFFF);
                send_load(tgam_pkg::OP_LOC_ENTRY, 3'd6, 8'd255, 32'd0);
                // zero output stride
                send_load(tgam_pkg::OP_OUT_STRIDE, 3'd0, 8'd0, 32'd0);
                send_map($urandom, 1'b1);
                send_load(tgam_pkg::OP_OUT_STRIDE, 3'd0, 8'hFF, tensor_total[31:0] / 4);
                // overflow through a huge locator value and source stride
                send_load(tgam_pkg::OP_LOC_ENTRY, 3'd0, 8'd1, 32'hFFFF_FFFF);
                send_load(tgam_pkg::OP_SRC_STRIDE, 3'd0, 8'd0, 32'hFFFF_FFFF);
                send_map(out_stride[0], 1'b0);
                send_load(tgam_pkg::OP_SRC_STRIDE, 3'd0, 8'd0, 32'd7);
                send_load(tgam_pkg::OP_LOC_ENTRY, 3'd0, 8'd1, 32'd2);
                // locator index beyond the table
                send_map(32'hFFFF_FFF0, 1'b1);
                send_map(tensor_total[31:0] - 1, 1'b1);
            end
            for (int i = 0; i < MAPS_PER_PH; i++) begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        d = 3'($urandom);
                        send_load(tgam_pkg::OP_SRC_STRIDE, d, 8'($urandom),
                                  rand_src_stride());
                    end
                    2: begin
                        // occasionally a zero output stride, otherwise keep the shape
                        d = 3'($urandom);
                        send_load(tgam_pkg::OP_OUT_STRIDE, d, 8'($urandom),
                                  ($urandom_range(0, 3) == 0) ? 32'd0 : out_stride[d]);
                    end
                    3, 4: send_load(tgam_pkg::OP_LOC_ENTRY, 3'($urandom), 8'($urandom),
                                    $urandom);
                    5: begin
                        d = 3'($urandom);
                        send_load(tgam_pkg::OP_LOC_ENTRY, d,
                                  8'($urandom_range(0, int'(dim_size[d]) - 1)),
                                  rand_loc_value(d));
                    end
                    default: ;
                endcase
                send_map(rand_position(), 1'($urandom_range(0, 1)));
            end
        end
        drain();
        if (n_fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // input driver
    always @(posedge i_clk) begin
        t_gather_item it;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_axis_tready) begin
            if (s_tvalid) n_accepted <= n_accepted + 1;
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
                it = pending_items.pop_front();
                s_tdata <= {5'd0, it.pos, it.value, it.entry, it.dim};
                s_tuser <= it.op;
                s_tlast <= it.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off once the stream is running
    always @(posedge i_clk) begin
        if (!rx_hold_done && n_accepted >= 150) begin
            rx_hold <= 600;
            rx_hold_done <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_addr_result e;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                if (expected_addrs.size() == 0) begin
                    $error("unexpected item: src_addr %h error %0d", o_m_axis_tdata,
                           o_m_axis_tuser);
                    n_fails = n_fails + 1;
                end else begin
                    e = expected_addrs.pop_front();
                    if (o_m_axis_tdata !== e.addr) begin
                        $error("src_addr: expected %h actual %h", e.addr, o_m_axis_tdata);
                        n_fails = n_fails + 1;
                    end
                    if (o_m_axis_tuser !== e.err) begin
                        $error("error: expected %0d actual %0d", e.err, o_m_axis_tuser);
                        n_fails = n_fails + 1;
                    end
                    if (o_m_axis_tlast !== e.last) begin
                        $error("last_out: expected %b actual %b", e.last, o_m_axis_tlast);
                        n_fails = n_fails + 1;
                    end
                end
            end
            m_tready <= (rx_hold == 0) && ($urandom_range(0, 99) >= rx_idle_pct());
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// File: filelist.f
hdl/tgam_pkg.sv
hdl/tgam_div_stage.sv
hdl/tgam_cell.sv
hdl/tensor_gather_address_map_unit.sv
dv/tb_top.sv
